FILE: rtl/ip_connection_rate_blocker_core_assert.svh
// assertion macros shared by the connection rate blocker modules
`ifndef IP_CONNECTION_RATE_BLOCKER_CORE_ASSERT_SVH
`define IP_CONNECTION_RATE_BLOCKER_CORE_ASSERT_SVH

// same-cycle implication, sampled on clk, off while arst_n is low
`define IRB_ASSERT_IMP(lbl, a, b, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (a) |-> (b)) else $error(msg);

// next-cycle implication, sampled on clk, off while arst_n is low
`define IRB_ASSERT_NXT(lbl, a, b, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (a) |=> (b)) else $error(msg);

`endif

FILE: rtl/irb_pkg.sv
// types and constants of the connection rate blocker
`timescale 1ns / 1ps

package irb_pkg;

	localparam int ADDR_W    = 32;
	localparam int COUNT_W   = 16;
	localparam int TIME_W    = 32;
	localparam int THR_W     = 16;
	localparam int WIN_W     = 16;
	localparam int BLK_W     = 20;
	localparam int CFG_W     = 20;
	localparam int CFG_IDX_W = 2;

	typedef logic [1:0] cmd_t;
	localparam cmd_t CMD_CONNECT = 2'd0;
	localparam cmd_t CMD_QUERY   = 2'd1;
	localparam cmd_t CMD_SWEEP   = 2'd2;

	typedef logic [CFG_IDX_W-1:0] cfg_idx_t;
	localparam cfg_idx_t REG_THRESHOLD = 2'd0;
	localparam cfg_idx_t REG_WINDOW    = 2'd1;
	localparam cfg_idx_t REG_BLOCK     = 2'd2;

	localparam logic [THR_W-1:0]   THRESHOLD_RST = 16'd10;
	localparam logic [WIN_W-1:0]   WINDOW_RST    = 16'd10;
	localparam logic [BLK_W-1:0]   BLOCK_RST     = 20'd3600;
	localparam logic [COUNT_W-1:0] COUNT_MAX     = 16'hFFFF;

	typedef struct packed {
		logic [ADDR_W-1:0]  addr;
		logic [COUNT_W-1:0] count;
		logic [TIME_W-1:0]  expiry;
		logic               blocked;
	} entry_t;

	typedef struct packed {
		logic start;
		logic issue;
		logic commit;
	} ctrl_cmd_t;

	typedef struct packed {
		logic issue_last;
	} dp_status_t;

	typedef enum logic [3:0] {
		ST_IDLE   = 4'b0001,
		ST_SCAN   = 4'b0010,
		ST_DRAIN  = 4'b0100,
		ST_COMMIT = 4'b1000
	} state_t;

endpackage

FILE: rtl/irb_datapath.sv
// slot table, config registers, scan evaluation and result register
`timescale 1ns / 1ps

module irb_datapath #(
	parameter int ENTRIES = 64
) (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      cfg_write_en,
	input  irb_pkg::cfg_idx_t         cfg_index,
	input  logic [irb_pkg::CFG_W-1:0] cfg_data,
	input  irb_pkg::cmd_t             cmd,
	input  logic [irb_pkg::ADDR_W-1:0] address_key,
	input  logic [irb_pkg::TIME_W-1:0] now_seconds,
	input  irb_pkg::ctrl_cmd_t        ctl,
	output irb_pkg::dp_status_t       sts,
	output logic                      accepted,
	output logic                      is_blocked,
	output logic                      table_full
);
	import irb_pkg::*;

	localparam int IDX_W = $clog2(ENTRIES);

	logic [THR_W-1:0]  thr_q;
	logic [WIN_W-1:0]  win_q;
	logic [BLK_W-1:0]  blk_q;

	cmd_t              cmd_q;
	logic [ADDR_W-1:0] key_q;
	logic [TIME_W-1:0] now_q;

	entry_t            mem [ENTRIES];
	logic [ENTRIES-1:0] used_q;

	logic [IDX_W-1:0]  rd_idx_q;
	logic [IDX_W-1:0]  idx_s1;
	logic              vld_s1;
	entry_t            rd_s1;

	logic              found_q;
	logic [IDX_W-1:0]  match_idx_q;
	entry_t            match_ent_q;
	logic              free_found_q;
	logic [IDX_W-1:0]  free_idx_q;
	logic              removed_q;

	logic              accepted_q;
	logic              is_blocked_q;
	logic              table_full_q;

	logic              cur_used;
	logic              cur_match;
	logic              cur_expired;
	logic              sweep_remove;
	logic              sweep_block;

	logic              mem_we;
	logic [IDX_W-1:0]  mem_wa;
	entry_t            mem_wd;
	logic              set_used;
	logic              res_acc;
	logic              res_blk;
	logic              res_full;
	logic [TIME_W-1:0] new_expiry;
	logic [COUNT_W-1:0] sat_count;

	// config registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			thr_q <= THRESHOLD_RST;
			win_q <= WINDOW_RST;
			blk_q <= BLOCK_RST;
		end else if (cfg_write_en) begin
			unique case (cfg_index)
				REG_THRESHOLD: thr_q <= cfg_data[THR_W-1:0];
				REG_WINDOW:    win_q <= cfg_data[WIN_W-1:0];
				REG_BLOCK:     blk_q <= cfg_data[BLK_W-1:0];
				default: ;
			endcase
		end
	end

	// evaluation of the slot read in the previous cycle
	always_comb begin
		cur_used     = used_q[idx_s1];
		cur_match    = vld_s1 && cur_used && (rd_s1.addr == key_q);
		cur_expired  = rd_s1.expiry < now_q;
		sweep_remove = vld_s1 && (cmd_q == CMD_SWEEP) && cur_used && cur_expired && !removed_q;
		sweep_block  = vld_s1 && (cmd_q == CMD_SWEEP) && cur_used && !sweep_remove
			&& !rd_s1.blocked && (rd_s1.count >= thr_q);
	end

	// commit of a connect, blocking write of a swept slot, and the result of any command
	always_comb begin
		new_expiry = now_q + TIME_W'(win_q);
		sat_count  = (match_ent_q.count == COUNT_MAX) ? match_ent_q.count
			: match_ent_q.count + COUNT_W'(1);
		mem_we   = 1'b0;
		mem_wa   = idx_s1;
		mem_wd   = rd_s1;
		set_used = 1'b0;
		res_acc  = 1'b0;
		res_blk  = 1'b0;
		res_full = 1'b0;
		if (sweep_block) begin
			mem_we         = 1'b1;
			mem_wd.blocked = 1'b1;
			mem_wd.expiry  = rd_s1.expiry + TIME_W'(blk_q);
		end
		case (cmd_q)
			CMD_CONNECT: begin
				if (found_q && match_ent_q.blocked) begin
					res_blk = 1'b1;
				end else if (found_q) begin
					res_acc = 1'b1;
					mem_we  = ctl.commit;
					mem_wa  = match_idx_q;
					mem_wd  = match_ent_q;
					mem_wd.count = sat_count;
					if (match_ent_q.expiry == '0) begin
						mem_wd.expiry = new_expiry;
					end
				end else if (free_found_q) begin
					res_acc        = 1'b1;
					set_used       = ctl.commit;
					mem_we         = ctl.commit;
					mem_wa         = free_idx_q;
					mem_wd.addr    = key_q;
					mem_wd.count   = COUNT_W'(1);
					mem_wd.expiry  = new_expiry;
					mem_wd.blocked = 1'b0;
				end else begin
					res_full = 1'b1;
				end
			end
			CMD_QUERY: begin
				res_blk = found_q && match_ent_q.blocked;
			end
			default: ;
		endcase
	end

	// slot memory, registered read
	always_ff @(posedge clk) begin
		if (mem_we) begin
			mem[mem_wa] <= mem_wd;
		end
		rd_s1 <= mem[rd_idx_q];
	end

	always_ff @(posedge clk) begin
		if (ctl.start) begin
			cmd_q <= cmd;
			key_q <= address_key;
			now_q <= now_seconds;
		end
		if (cur_match && !found_q) begin
			match_idx_q <= idx_s1;
			match_ent_q <= rd_s1;
		end
		if (vld_s1 && !cur_used && !free_found_q) begin
			free_idx_q <= idx_s1;
		end
		idx_s1 <= rd_idx_q;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			used_q       <= '0;
			rd_idx_q     <= '0;
			vld_s1       <= 1'b0;
			found_q      <= 1'b0;
			free_found_q <= 1'b0;
			removed_q    <= 1'b0;
			accepted_q   <= 1'b0;
			is_blocked_q <= 1'b0;
			table_full_q <= 1'b0;
		end else begin
			vld_s1 <= ctl.issue;
			if (ctl.start) begin
				rd_idx_q     <= '0;
				found_q      <= 1'b0;
				free_found_q <= 1'b0;
				removed_q    <= 1'b0;
			end else begin
				if (ctl.issue) begin
					rd_idx_q <= rd_idx_q + IDX_W'(1);
				end
				if (cur_match) begin
					found_q <= 1'b1;
				end
				if (vld_s1 && !cur_used) begin
					free_found_q <= 1'b1;
				end
				if (sweep_remove) begin
					removed_q <= 1'b1;
				end
			end
			if (sweep_remove) begin
				used_q[idx_s1] <= 1'b0;
			end
			if (set_used) begin
				used_q[free_idx_q] <= 1'b1;
			end
			if (ctl.commit) begin
				accepted_q   <= res_acc;
				is_blocked_q <= res_blk;
				table_full_q <= res_full;
			end
		end
	end

	assign sts.issue_last = (rd_idx_q == IDX_W'(ENTRIES - 1));
	assign accepted       = accepted_q;
	assign is_blocked     = is_blocked_q;
	assign table_full     = table_full_q;

	`include "ip_connection_rate_blocker_core_assert.svh"

	`IRB_ASSERT_IMP(a_acc_not_full, accepted_q, !table_full_q && !is_blocked_q, "accepted beat also flagged refused")
	`IRB_ASSERT_IMP(a_one_removal, sweep_remove, !removed_q, "sweep removed a second slot")
	`IRB_ASSERT_IMP(a_no_write_clash, ctl.commit, !vld_s1, "commit write overlaps a scan write")

endmodule

FILE: rtl/irb_ctrl.sv
// controller state machine: accept, scan, drain, commit
`timescale 1ns / 1ps

module irb_ctrl (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                in_valid,
	output logic                in_ready,
	output logic                out_valid,
	input  logic                out_ready,
	input  irb_pkg::dp_status_t sts,
	output irb_pkg::ctrl_cmd_t  ctl
);
	import irb_pkg::*;

	state_t state_q;
	state_t state_nx;
	logic   out_valid_q;

	always_comb begin
		ctl.start  = (state_q == ST_IDLE) && in_valid;
		ctl.issue  = (state_q == ST_SCAN);
		ctl.commit = (state_q == ST_COMMIT) && (!out_valid_q || out_ready);
		state_nx   = state_q;
		unique case (state_q)
			ST_IDLE: begin
				if (in_valid) begin
					state_nx = ST_SCAN;
				end
			end
			ST_SCAN: begin
				if (sts.issue_last) begin
					state_nx = ST_DRAIN;
				end
			end
			ST_DRAIN: begin
				state_nx = ST_COMMIT;
			end
			ST_COMMIT: begin
				if (ctl.commit) begin
					state_nx = ST_IDLE;
				end
			end
			default: begin
				state_nx = ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_nx;
			if (ctl.commit) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	assign in_ready  = (state_q == ST_IDLE);
	assign out_valid = out_valid_q;

	`include "ip_connection_rate_blocker_core_assert.svh"

	`IRB_ASSERT_NXT(a_accept_scans, in_valid && in_ready, state_q == ST_SCAN, "accepted beat did not start a scan")
	`IRB_ASSERT_NXT(a_commit_shows, ctl.commit, out_valid_q, "commit did not raise out_valid")
	`IRB_ASSERT_NXT(a_last_drains, ctl.issue && sts.issue_last, state_q == ST_DRAIN, "scan ran past the last slot")

endmodule

FILE: rtl/ip_connection_rate_blocker_core.sv
// top level of the per-address connection rate blocker
`timescale 1ns / 1ps

// Usage:
// The input channel (in_valid/in_ready) takes one beat of cmd, address_key and
// now_seconds: connect, blocked query or sweep. Each input beat yields exactly
// one output beat (accepted, is_blocked, table_full) on out_valid/out_ready.
// Every command scans all ENTRIES slots, one slot per cycle through the single
// read port of the slot memory, then passes a drain and a commit state; a new
// input beat is taken only once the previous one has been committed.
// The result sits in an output register; while the receiver stalls the next
// input beat is still accepted and scanned, and only its commit waits until
// the previous output beat is taken.
// Configuration registers (threshold, window, block time) are to be written through
// cfg_write_en/cfg_index/cfg_data while the block is idle; the block does not enforce this.
// Reset empties the table at once (per-slot used bits) and loads the register
// defaults; no clearing pass is needed and in_ready is high right after reset.
module ip_connection_rate_blocker_core #(
	parameter int ENTRIES = 64
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          cfg_write_en,
	input  logic [irb_pkg::CFG_IDX_W-1:0] cfg_index,
	input  logic [irb_pkg::CFG_W-1:0]     cfg_data,
	input  logic                          in_valid,
	output logic                          in_ready,
	input  logic [1:0]                    cmd,
	input  logic [irb_pkg::ADDR_W-1:0]    address_key,
	input  logic [irb_pkg::TIME_W-1:0]    now_seconds,
	output logic                          out_valid,
	input  logic                          out_ready,
	output logic                          accepted,
	output logic                          is_blocked,
	output logic                          table_full
);
	import irb_pkg::*;

	ctrl_cmd_t  ctl;
	dp_status_t sts;

	irb_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.sts       (sts),
		.ctl       (ctl)
	);

	irb_datapath #(
		.ENTRIES (ENTRIES)
	) u_datapath (
		.clk          (clk),
		.arst_n       (arst_n),
		.cfg_write_en (cfg_write_en),
		.cfg_index    (cfg_index),
		.cfg_data     (cfg_data),
		.cmd          (cmd),
		.address_key  (address_key),
		.now_seconds  (now_seconds),
		.ctl          (ctl),
		.sts          (sts),
		.accepted     (accepted),
		.is_blocked   (is_blocked),
		.table_full   (table_full)
	);

endmodule
